@@ hdl/mmt_pkg.sv @@
// Shared types, constants and helpers for the mesh multiplicity table.
package mmt_pkg;

    localparam int MAX_LINES = 64;
    localparam int LINE_W    = $clog2(MAX_LINES);
    localparam int CNT_W     = LINE_W + 1;
    localparam int MULT_W    = 4;
    localparam int RES_W     = 6;
    localparam int OP_W      = 3;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;
    localparam int DEPTH     = 2 * MAX_LINES * MAX_LINES;
    localparam int ADDR_W    = $clog2(DEPTH);

    localparam logic [OP_W-1:0] OP_RANGE_MIN = 3'd0;
    localparam logic [OP_W-1:0] OP_SET       = 3'd1;
    localparam logic [OP_W-1:0] OP_ADD       = 3'd2;
    localparam logic [OP_W-1:0] OP_EXTENT    = 3'd3;
    localparam logic [OP_W-1:0] OP_LINE_MAX  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_LINES_X = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_LINES_Y = 1'd1;

    localparam logic [MULT_W-1:0] MULT_MAX = 4'd15;

    typedef struct packed {
        logic [CNT_W-1:0] lines_x;
        logic [CNT_W-1:0] lines_y;
    } grid_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [MULT_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

    function automatic logic [CNT_W-1:0] eff_lines(input logic [CFG_W-1:0] v);
        logic [CNT_W-1:0] r;
        if (CNT_W'(v) < CNT_W'(2)) begin
            r = CNT_W'(2);
        end
        else if (CNT_W'(v) > CNT_W'(MAX_LINES)) begin
            r = CNT_W'(MAX_LINES);
        end
        else begin
            r = CNT_W'(v);
        end
        return r;
    endfunction

endpackage

@@ hdl/mmt_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module mmt_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/mmt_seq.sv @@
// Operation sequencer: clearing pass, segment walk and read-modify-write.
module mmt_seq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [mmt_pkg::OP_W-1:0]      operation,
    input  logic                          direction,
    input  logic [mmt_pkg::LINE_W-1:0]    line_index,
    input  logic [mmt_pkg::LINE_W-1:0]    range_start,
    input  logic [mmt_pkg::LINE_W-1:0]    range_end,
    input  logic [mmt_pkg::MULT_W-1:0]    mult_value,
    input  mmt_pkg::grid_t                grid,
    output mmt_pkg::ram_req_t             ram_req,
    input  logic [mmt_pkg::MULT_W-1:0]    ram_rdata,
    output logic                          done,
    output logic [mmt_pkg::RES_W-1:0]     result_value,
    output logic                          range_error
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_RUN   = 2'd2;

    logic [1:0]                   state_reg, state_next;
    logic [mmt_pkg::ADDR_W-1:0]   clr_reg, clr_next;
    logic                         pend_reg, pend_next;
    logic                         done_reg, done_next;

    logic [mmt_pkg::OP_W-1:0]     op_reg, op_next;
    logic                         dir_reg, dir_next;
    logic [mmt_pkg::LINE_W-1:0]   line_reg, line_next;
    logic [mmt_pkg::MULT_W-1:0]   mv_reg, mv_next;
    logic [mmt_pkg::CNT_W-1:0]    issue_reg, issue_next;
    logic [mmt_pkg::CNT_W-1:0]    bound_reg, bound_next;
    logic [mmt_pkg::LINE_W-1:0]   pseg_reg, pseg_next;
    logic [mmt_pkg::RES_W-1:0]    acc_reg, acc_next;
    logic [mmt_pkg::RES_W-1:0]    result_reg, result_next;
    logic                         error_reg, error_next;

    logic [mmt_pkg::CNT_W-1:0]    nlines;
    logic [mmt_pkg::CNT_W-1:0]    nseg;
    logic                         line_ok;
    logic                         range_ok;
    logic                         can_issue;
    logic                         stop;
    logic                         finish;
    logic [mmt_pkg::MULT_W:0]     sum;

    assign nlines   = direction ? grid.lines_y : grid.lines_x;
    assign nseg     = (direction ? grid.lines_x : grid.lines_y) - mmt_pkg::CNT_W'(1);
    assign line_ok  = mmt_pkg::CNT_W'(line_index) < nlines;
    assign range_ok = (range_end > range_start) && (mmt_pkg::CNT_W'(range_end) <= nseg);

    assign can_issue = issue_reg < bound_reg;
    assign sum       = {1'b0, ram_rdata} + {1'b0, mv_reg};

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        pend_next   = 1'b0;
        done_next   = 1'b0;
        op_next     = op_reg;
        dir_next    = dir_reg;
        line_next   = line_reg;
        mv_next     = mv_reg;
        issue_next  = issue_reg;
        bound_next  = bound_reg;
        pseg_next   = pseg_reg;
        acc_next    = acc_reg;
        result_next = result_reg;
        error_next  = error_reg;
        stop        = 1'b0;
        finish      = 1'b0;

        ram_req.we    = 1'b0;
        ram_req.waddr = {dir_reg, line_reg, pseg_reg};
        ram_req.wdata = mv_reg;
        ram_req.raddr = {dir_reg, line_reg, issue_reg[mmt_pkg::LINE_W-1:0]};

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = clr_reg;
                ram_req.wdata = '0;
                clr_next      = clr_reg + mmt_pkg::ADDR_W'(1);
                if (clr_reg == mmt_pkg::ADDR_W'(mmt_pkg::DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next     = operation;
                    dir_next    = direction;
                    line_next   = line_index;
                    mv_next     = mult_value;
                    issue_next  = mmt_pkg::CNT_W'(range_start);
                    bound_next  = mmt_pkg::CNT_W'(range_end);
                    acc_next    = '0;
                    result_next = '0;
                    error_next  = 1'b0;
                    case (operation) inside
                        mmt_pkg::OP_RANGE_MIN:
                        begin
                            acc_next = mmt_pkg::RES_W'(mmt_pkg::MULT_MAX);
                            if (line_ok && range_ok)
                            begin
                                state_next = ST_RUN;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        mmt_pkg::OP_SET, mmt_pkg::OP_ADD:
                        begin
                            if (line_ok && range_ok)
                            begin
                                state_next = ST_RUN;
                            end
                            else
                            begin
                                done_next  = 1'b1;
                                error_next = 1'b1;
                            end
                        end
                        mmt_pkg::OP_EXTENT:
                        begin
                            bound_next = nseg;
                            if (line_ok)
                            begin
                                state_next = ST_RUN;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        mmt_pkg::OP_LINE_MAX:
                        begin
                            issue_next = '0;
                            bound_next = nseg;
                            if (line_ok)
                            begin
                                state_next = ST_RUN;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_RUN:
            begin
                // read data in this cycle belongs to segment pseg_reg
                if (pend_reg)
                begin
                    case (op_reg)
                        mmt_pkg::OP_RANGE_MIN:
                        begin
                            if (ram_rdata < acc_reg[mmt_pkg::MULT_W-1:0])
                            begin
                                acc_next = mmt_pkg::RES_W'(ram_rdata);
                            end
                        end
                        mmt_pkg::OP_LINE_MAX:
                        begin
                            if (ram_rdata > acc_reg[mmt_pkg::MULT_W-1:0])
                            begin
                                acc_next = mmt_pkg::RES_W'(ram_rdata);
                            end
                        end
                        mmt_pkg::OP_EXTENT:
                        begin
                            if (ram_rdata >= mv_reg)
                            begin
                                acc_next = acc_reg + mmt_pkg::RES_W'(1);
                            end
                            else
                            begin
                                stop = 1'b1;
                            end
                        end
                        mmt_pkg::OP_SET:
                        begin
                            ram_req.we = 1'b1;
                        end
                        mmt_pkg::OP_ADD:
                        begin
                            ram_req.we = 1'b1;
                            if (sum[mmt_pkg::MULT_W])
                            begin
                                ram_req.wdata = mmt_pkg::MULT_MAX;
                            end
                            else
                            begin
                                ram_req.wdata = sum[mmt_pkg::MULT_W-1:0];
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end

                finish = stop || !can_issue;
                if (can_issue && !stop)
                begin
                    issue_next = issue_reg + mmt_pkg::CNT_W'(1);
                    pseg_next  = issue_reg[mmt_pkg::LINE_W-1:0];
                    pend_next  = 1'b1;
                end
                if (finish)
                begin
                    state_next  = ST_IDLE;
                    done_next   = 1'b1;
                    result_next = acc_next;
                    error_next  = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        dir_reg    <= dir_next;
        line_reg   <= line_next;
        mv_reg     <= mv_next;
        issue_reg  <= issue_next;
        bound_reg  <= bound_next;
        pseg_reg   <= pseg_next;
        acc_reg    <= acc_next;
        result_reg <= result_next;
        error_reg  <= error_next;
    end

    assign busy         = state_reg != ST_IDLE;
    assign done         = done_reg;
    assign result_value = result_reg;
    assign range_error  = error_reg;

endmodule

@@ hdl/mesh_multiplicity_table_core.sv @@
// Top level of the mesh multiplicity table: grid registers, sequencer and table RAM.
// Operations: a rejected or unused operation strobes done without a table access; an
// operation that walks segments does one RAM read per segment, result strobed after the last.
// One operation at a time: a new start is taken only while busy is low.
// Reset: grid registers go to 64 lines; the table RAM is zeroed by a clearing pass
// of 8192 entries, one entry a cycle, with busy high. Results cannot be stalled.
module mesh_multiplicity_table_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [mmt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mmt_pkg::CFG_W-1:0]      cfg_data,
    input  logic                           start,
    output logic                           busy,
    input  logic [mmt_pkg::OP_W-1:0]       operation,
    input  logic                           direction,
    input  logic [mmt_pkg::LINE_W-1:0]     line_index,
    input  logic [mmt_pkg::LINE_W-1:0]     range_start,
    input  logic [mmt_pkg::LINE_W-1:0]     range_end,
    input  logic [mmt_pkg::MULT_W-1:0]     mult_value,
    output logic                           done,
    output logic [mmt_pkg::RES_W-1:0]      result_value,
    output logic                           range_error
);

    logic [mmt_pkg::CFG_W-1:0]  nlx_reg, nlx_next;
    logic [mmt_pkg::CFG_W-1:0]  nly_reg, nly_next;
    mmt_pkg::grid_t             grid;
    mmt_pkg::ram_req_t          ram_req;
    logic [mmt_pkg::MULT_W-1:0] ram_rdata;

    always_comb
    begin
        nlx_next = nlx_reg;
        nly_next = nly_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                mmt_pkg::REG_NUM_LINES_X: nlx_next = cfg_data;
                mmt_pkg::REG_NUM_LINES_Y: nly_next = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nlx_reg <= mmt_pkg::CFG_W'(mmt_pkg::MAX_LINES);
            nly_reg <= mmt_pkg::CFG_W'(mmt_pkg::MAX_LINES);
        end
        else
        begin
            nlx_reg <= nlx_next;
            nly_reg <= nly_next;
        end
    end

    assign grid.lines_x = mmt_pkg::eff_lines(nlx_reg);
    assign grid.lines_y = mmt_pkg::eff_lines(nly_reg);

    mmt_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .direction    (direction),
        .line_index   (line_index),
        .range_start  (range_start),
        .range_end    (range_end),
        .mult_value   (mult_value),
        .grid         (grid),
        .ram_req      (ram_req),
        .ram_rdata    (ram_rdata),
        .done         (done),
        .result_value (result_value),
        .range_error  (range_error)
    );

    mmt_ram #(
        .WIDTH (mmt_pkg::MULT_W),
        .DEPTH (mmt_pkg::DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

endmodule
